### hw/rtl/b64lw_pkg.sv
// Package for the base64 line-wrapping encoder: character constants, the
// job record passed from the front end to the back end, and the alphabet map.
// No dependencies.
package b64lw_pkg;

    localparam logic [7:0] LIMIT_RESET = 8'd72;
    localparam logic [7:0] CHAR_LF     = 8'h0A;
    localparam logic [7:0] CHAR_PAD    = 8'h3D;
    localparam logic [7:0] GROUP_COLS  = 8'd4;

    // Characters one input item can cause: four symbols and one line feed.
    localparam int unsigned MAX_CHARS = 5;
    localparam int unsigned IDX_W     = $clog2(MAX_CHARS);

    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [MAX_CHARS-1:0][7:0] chars;
        logic [IDX_W-1:0]          count;
        logic                      done;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // Standard base64 alphabet, index 0..63 to ASCII.
    function automatic logic [7:0] sym(input logic [5:0] v);
        logic [7:0] w;
        logic [7:0] r;
        w = {2'b00, v};
        if (w < 8'd26) begin
            r = 8'h41 + w;
        end else if (w < 8'd52) begin
            r = 8'h61 + (w - 8'd26);
        end else if (w < 8'd62) begin
            r = 8'h30 + (w - 8'd52);
        end else if (w == 8'd62) begin
            r = 8'h2B;
        end else begin
            r = 8'h2F;
        end
        return r;
    endfunction

endpackage

### hw/rtl/b64lw_front.sv
// Front end of the base64 encoder: holds pending bytes and the line column,
// and turns each accepted beat into a job of up to five characters.
// Depends on b64lw_pkg.
module b64lw_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [7:0]          line_limit,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,
    input  logic                s_tuser,
    input  logic                s_tlast,
    input  b64lw_pkg::q_status_t q_status,
    output logic                push,
    output b64lw_pkg::job_t     push_job
);
    import b64lw_pkg::*;

    logic [7:0] held0_reg, held0_next;
    logic [7:0] held1_reg, held1_next;
    logic [1:0] held_cnt_reg, held_cnt_next;
    logic [7:0] col_reg, col_next;

    logic       accept;
    logic       full_grp;
    logic [1:0] cnt_a;
    logic [7:0] h0_a, h1_a;
    logic [8:0] col9;
    logic       wrap;
    logic [7:0] col_a;
    logic       pad_grp;
    logic [7:0] col_p4;
    logic [7:0] col_b;
    logic       lf_end;
    logic       grp;
    logic       lf;
    logic [3:0][7:0] g;

    assign s_tready = !q_status.full;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        full_grp = s_tuser && held_cnt_reg[1];
        cnt_a    = held_cnt_reg;
        h0_a     = held0_reg;
        h1_a     = held1_reg;
        if (full_grp) begin
            cnt_a = 2'd0;
            h0_a  = 8'd0;
            h1_a  = 8'd0;
        end else if (s_tuser) begin
            cnt_a = held_cnt_reg + 2'd1;
            if (held_cnt_reg[0]) begin
                h1_a = s_tdata;
            end else begin
                h0_a = s_tdata;
            end
        end

        // One extra bit so a column sum above 255 does not wrap and meets any limit.
        col9 = {1'b0, col_reg} + {1'b0, GROUP_COLS};
        wrap = full_grp && (col9 >= {1'b0, line_limit});
        if (!full_grp) begin
            col_a = col_reg;
        end else if (wrap) begin
            col_a = 8'd0;
        end else begin
            col_a = col9[7:0];
        end

        pad_grp = s_tlast && (cnt_a != 2'd0);
        col_p4  = col_a + GROUP_COLS;
        if (!pad_grp) begin
            col_b = col_a;
        end else if (col_p4 == 8'd0) begin
            col_b = GROUP_COLS;
        end else begin
            col_b = col_p4;
        end
        lf_end = s_tlast && (col_b != 8'd0);

        grp = full_grp || pad_grp;
        lf  = wrap || lf_end;

        if (full_grp) begin
            g[0] = sym(held0_reg[7:2]);
            g[1] = sym({held0_reg[1:0], held1_reg[7:4]});
            g[2] = sym({held1_reg[3:0], s_tdata[7:6]});
            g[3] = sym(s_tdata[5:0]);
        end else begin
            g[0] = sym(h0_a[7:2]);
            if (cnt_a == 2'd1) begin
                g[1] = sym({h0_a[1:0], 4'b0000});
                g[2] = CHAR_PAD;
            end else begin
                g[1] = sym({h0_a[1:0], h1_a[7:4]});
                g[2] = sym({h1_a[3:0], 2'b00});
            end
            g[3] = CHAR_PAD;
        end

        push_job.chars[0] = grp ? g[0] : CHAR_LF;
        push_job.chars[1] = g[1];
        push_job.chars[2] = g[2];
        push_job.chars[3] = g[3];
        push_job.chars[4] = CHAR_LF;
        push_job.count    = (grp ? IDX_W'(4) : IDX_W'(0)) + (lf ? IDX_W'(1) : IDX_W'(0));
        push_job.done     = s_tlast;
        push              = accept && (grp || lf);

        held0_next    = held0_reg;
        held1_next    = held1_reg;
        held_cnt_next = held_cnt_reg;
        col_next      = col_reg;
        if (accept) begin
            if (s_tlast) begin
                held0_next    = 8'd0;
                held1_next    = 8'd0;
                held_cnt_next = 2'd0;
                col_next      = 8'd0;
            end else begin
                held0_next    = h0_a;
                held1_next    = h1_a;
                held_cnt_next = cnt_a;
                col_next      = col_a;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held0_reg    <= 8'd0;
            held1_reg    <= 8'd0;
            held_cnt_reg <= 2'd0;
            col_reg      <= 8'd0;
        end else begin
            held0_reg    <= held0_next;
            held1_reg    <= held1_next;
            held_cnt_reg <= held_cnt_next;
            col_reg      <= col_next;
        end
    end

endmodule

### hw/rtl/b64lw_queue.sv
// Short job queue between the encoder front end and the character back end.
// Depends on b64lw_pkg.
module b64lw_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  b64lw_pkg::job_t      push_job,
    input  logic                 pop,
    output b64lw_pkg::job_t      head_job,
    output b64lw_pkg::q_status_t q_status
);
    import b64lw_pkg::*;

    job_t              mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;

    assign head_job       = mem[rd_ptr_reg];
    assign q_status.full  = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_status.empty = (cnt_reg == QCNT_W'(0));

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? QPTR_W'(0)
                                                                  : wr_ptr_reg + QPTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? QPTR_W'(0)
                                                                  : rd_ptr_reg + QPTR_W'(1);
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + QCNT_W'(1);
        end else if (pop && !push) begin
            cnt_next = cnt_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

### hw/rtl/b64lw_back.sv
// Back end of the base64 encoder: sends the characters of the head job one
// beat at a time and retires the job after its last character.
// Depends on b64lw_pkg.
module b64lw_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  b64lw_pkg::job_t      head_job,
    input  b64lw_pkg::q_status_t q_status,
    output logic                 pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata,
    output logic                 m_tlast,
    output logic                 m_tuser
);
    import b64lw_pkg::*;

    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             last;

    assign m_tvalid = !q_status.empty;
    assign last     = (idx_reg == head_job.count - IDX_W'(1));
    assign m_tdata  = head_job.chars[idx_reg];
    assign m_tlast  = last;
    assign m_tuser  = last && head_job.done;
    assign pop      = m_tvalid && m_tready && last;

    always_comb begin
        idx_next = idx_reg;
        if (m_tvalid && m_tready) begin
            idx_next = last ? IDX_W'(0) : idx_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= '0;
        end else begin
            idx_reg <= idx_next;
        end
    end

endmodule

### hw/rtl/base64_encoder_line_wrap.sv
// Top level of the streaming base64 encoder with line wrapping.
// Depends on b64lw_pkg, b64lw_front, b64lw_queue and b64lw_back.
//
// This block encodes a message, one byte per input beat, into standard
// base64 characters, one character per output beat. Every three bytes give
// four symbols, and a line feed follows a group once the line column reaches
// the configured limit (reset value 72). A beat with tlast set ends the
// message: a pending one- or two-byte group is sent with '=' padding, then a
// closing line feed if the column is nonzero, and all state clears. A beat
// with tuser low carries no byte. Each input beat causes zero to five
// characters; the last of them has m_tlast set, and m_tuser marks the last
// character caused by the tlast beat, if it causes any. The front end takes
// an input beat in every cycle in which the two-entry job queue has room, so
// input beats that cause no output flow at one per cycle. The first character
// of a beat is offered once its job, written into the queue on acceptance,
// reaches the head. The output side sends one character per cycle while
// m_tready is high, so a long message is paced by the back end. The line
// limit is written through the cfg channel, which is always ready; the user
// must write it only while the block is idle; the block does not enforce it.
module base64_encoder_line_wrap (
    input  logic       aclk,
    input  logic       aresetn,
    // Configuration: line_limit.
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data,
    // Input beats.
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       s_tuser,   // [0] has_byte
    input  logic       s_tlast,   // end_of_message
    // Output beats.
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_char
    output logic       m_tlast,   // run_last
    output logic       m_tuser    // [0] message_done
);
    import b64lw_pkg::*;

    logic [7:0] limit_reg, limit_next;
    logic       push;
    logic       pop;
    job_t       push_job;
    job_t       head_job;
    q_status_t  q_status;

    // The limit register takes any write; the encoder needs it stable
    // while a message is in progress.
    assign cfg_ready = 1'b1;

    always_comb begin
        limit_next = limit_reg;
        if (cfg_valid && cfg_ready) begin
            limit_next = cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= LIMIT_RESET;
        end else begin
            limit_reg <= limit_next;
        end
    end

    // Front end: classifies each beat, updates held bytes and column, and
    // builds the job of characters it causes.
    b64lw_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .line_limit (limit_reg),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tlast    (s_tlast),
        .q_status   (q_status),
        .push       (push),
        .push_job   (push_job)
    );

    // Queue that lets the front end keep taking beats while the back end
    // waits on the output side.
    b64lw_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .q_status (q_status)
    );

    // Back end: sends the head job one character per beat.
    b64lw_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head_job (head_job),
        .q_status (q_status),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    // The end-of-message mark only ever comes on the last character of a run.
    a_done_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> m_tlast)
        else $error("message_done set on a character that is not run_last");

    // The queue cannot be both full and empty.
    a_queue_sane: assert property (@(posedge aclk) disable iff (!aresetn)
        !(q_status.full && q_status.empty))
        else $error("job queue reports full and empty at once");

    // Output becomes valid only after an input beat was taken.
    a_out_after_in: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready))
        else $error("output beat appeared without an accepted input beat");

endmodule
